### hdl/sptc_pkg.sv
`default_nettype none
package sptc_pkg;

  localparam int unsigned BeamsDefault     = 2048;
  localparam int unsigned RangeBitsDefault = 16;
  localparam int unsigned RangeBitsMax     = 24;
  localparam int unsigned BeamW            = 11;
  localparam int unsigned QueueDepth       = 4;
  localparam int unsigned QueuePtrW        = $clog2(QueueDepth);
  localparam int unsigned QueueCntW        = $clog2(QueueDepth + 1);

  localparam int unsigned CordicIters = 28;
  localparam int unsigned VecW        = 44;   // x/y datapath, holds range * gain plus growth
  localparam int unsigned AngW        = 34;   // residual angle
  localparam int unsigned OutW        = 17;
  localparam logic [15:0] GainQ16     = 16'd39797;

  localparam logic signed [31:0] AngleBaseRst = -32'sd1620048779;
  localparam logic signed [15:0] XShiftRst    = 16'sd130;

  typedef enum logic [1:0] {
    REG_ANGLE_STEP = 2'd0,
    REG_ANGLE_BASE = 2'd1,
    REG_X_SHIFT    = 2'd2
  } reg_idx_e;

  localparam logic [31:0] AtanTab [CordicIters] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic [BeamW-1:0]        beam;
    logic [RangeBitsMax-1:0] range;
  } sptc_item_t;

  typedef struct packed {
    logic [QueueCntW-1:0] count;
    logic                 full;
    logic                 empty;
  } sptc_qstat_t;

endpackage
`default_nettype wire

### hdl/scan_polar_to_cartesian_filter.sv
`default_nettype none
// Laser scan filter: takes one range sample per request (beam index, range,
// valid flag in tuser), drops it when invalid, when its beam is beyond BEAMS,
// or when it equals the range last stored for that beam; otherwise it stores
// the range and emits (r*cos(a) + x_shift, r*sin(a)) with a = beam *
// angle_step + angle_base, saturated to 17 bits signed. Throughput is one
// sample per clock while the queue has room; a sample that yields a point
// passes the store lookup, the queue, the angle stage, the quadrant fold,
// 28 pipelined CORDIC steps and the output register. After reset the
// per-beam store is swept to zero, one entry per cycle, and s_axis_tready
// stays low until all BEAMS entries (2048 by default) are cleared.
// A four-entry queue sits between the store lookup and the CORDIC so the
// output may stall without blocking the next lookup until the queue fills.
// Write the registers only while the block is idle.
module scan_polar_to_cartesian_filter #(
  parameter int unsigned BEAMS      = sptc_pkg::BeamsDefault,
  parameter int unsigned RANGE_BITS = sptc_pkg::RangeBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // beam_index[10:0], range_mm[26:11]
  input  wire logic        s_axis_tuser,  // range_valid
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // point_beam[10:0], x_mm[27:11], y_mm[44:28]
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0]          angle_step_q;
  logic signed [31:0]   angle_base_q;
  logic signed [15:0]   x_shift_q;

  sptc_pkg::sptc_qstat_t qstat;
  sptc_pkg::sptc_item_t  push_item, head_item;
  logic                  push, pop;
  logic [sptc_pkg::BeamW-1:0] out_beam;
  logic signed [sptc_pkg::OutW-1:0] out_x, out_y;

  // Register writes; unknown indexes do nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_step_q <= '0;
      angle_base_q <= sptc_pkg::AngleBaseRst;
      x_shift_q    <= sptc_pkg::XShiftRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sptc_pkg::REG_ANGLE_STEP: angle_step_q <= cfg_data_i;
        sptc_pkg::REG_ANGLE_BASE: angle_base_q <= $signed(cfg_data_i);
        sptc_pkg::REG_X_SHIFT:    x_shift_q    <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  sptc_front #(.BEAMS(BEAMS), .RANGE_BITS(RANGE_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .beam_i        (s_axis_tdata[10:0]),
    .range_i       (s_axis_tdata[26:11]),
    .range_valid_i (s_axis_tuser),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  sptc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  sptc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .item_vld_i   (!qstat.empty),
    .pop_o        (pop),
    .angle_step_i (angle_step_q),
    .angle_base_i (angle_base_q),
    .x_shift_i    (x_shift_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_beam_o   (out_beam),
    .out_x_o      (out_x),
    .out_y_o      (out_y)
  );

  assign m_axis_tdata = {3'b000, out_y, out_x, out_beam};

endmodule
`default_nettype wire

### hdl/sptc_ram.sv
`default_nettype none
module sptc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/sptc_front.sv
`default_nettype none
module sptc_front #(
  parameter int unsigned BEAMS      = sptc_pkg::BeamsDefault,
  parameter int unsigned RANGE_BITS = sptc_pkg::RangeBitsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [sptc_pkg::BeamW-1:0] beam_i,
  input  wire logic [15:0]               range_i,
  input  wire logic                      range_valid_i,
  input  wire sptc_pkg::sptc_qstat_t     qstat_i,
  output logic                           push_o,
  output sptc_pkg::sptc_item_t           item_o
);

  localparam int unsigned AW = $clog2(BEAMS);

  logic [AW:0]            clr_cnt_d, clr_cnt_q;
  logic                   clr_d, clr_q;
  logic                   accept;
  logic [31:0]            beam_w, range_w;
  logic [AW-1:0]          addr;
  logic [RANGE_BITS-1:0]  rng;
  logic                   s1_vld_q, s1_ok_q;
  logic [AW-1:0]          s1_addr_q;
  logic [RANGE_BITS-1:0]  s1_rng_q;
  logic [sptc_pkg::BeamW-1:0] s1_beam_q;
  logic [RANGE_BITS-1:0]  rd_data, stored;
  logic                   keep;
  logic                   wr_vld_q;
  logic [AW-1:0]          wr_addr_q;
  logic [RANGE_BITS-1:0]  wr_data_q;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [RANGE_BITS-1:0]  ram_wdata;
  logic [sptc_pkg::QueueCntW:0] occ;

  assign beam_w  = 32'(beam_i);
  assign range_w = 32'(range_i);
  assign addr    = beam_w[AW-1:0];
  assign rng     = range_w[RANGE_BITS-1:0];

  // Room must cover the item already in the compare stage.
  assign occ        = (sptc_pkg::QueueCntW + 1)'(qstat_i.count) +
                      (sptc_pkg::QueueCntW + 1)'(s1_vld_q);
  assign in_ready_o = !clr_q && (occ < (sptc_pkg::QueueCntW + 1)'(sptc_pkg::QueueDepth));
  assign accept     = in_valid_i && in_ready_o;

  // Clear the store once after reset.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == (AW + 1)'(BEAMS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      s1_vld_q  <= accept;
      wr_vld_q  <= keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ok_q   <= range_valid_i && (beam_w < 32'(BEAMS));
      s1_addr_q <= addr;
      s1_rng_q  <= rng;
      s1_beam_q <= beam_i;
    end
    wr_addr_q <= s1_addr_q;
    wr_data_q <= s1_rng_q;
  end

  // Forward the write of the previous cycle, the RAM read missed it.
  assign stored = (wr_vld_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : rd_data;
  assign keep   = s1_vld_q && s1_ok_q && (stored != s1_rng_q);

  assign ram_we    = clr_q || keep;
  assign ram_waddr = clr_q ? clr_cnt_q[AW-1:0] : s1_addr_q;
  assign ram_wdata = clr_q ? '0 : s1_rng_q;

  sptc_ram #(.WIDTH(RANGE_BITS), .DEPTH(BEAMS)) u_last (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (rd_data)
  );

  assign push_o      = keep;
  assign item_o.beam  = s1_beam_q;
  assign item_o.range = sptc_pkg::RangeBitsMax'(s1_rng_q);

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_ready_o) else $error("input accepted during clear");
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !keep) else $error("compare stage active during clear");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !qstat_i.full) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

### hdl/sptc_queue.sv
`default_nettype none
module sptc_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sptc_pkg::sptc_item_t  item_i,
  input  wire logic                  pop_i,
  output sptc_pkg::sptc_item_t       item_o,
  output sptc_pkg::sptc_qstat_t      stat_o
);

  sptc_pkg::sptc_item_t            mem [sptc_pkg::QueueDepth];
  logic [sptc_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [sptc_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == sptc_pkg::QueueCntW'(sptc_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign item_o  = mem[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sptc_pkg::QueueCntW'(sptc_pkg::QueueDepth)) else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !stat_o.full) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

### hdl/sptc_back.sv
`default_nettype none
module sptc_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sptc_pkg::sptc_item_t  item_i,
  input  wire logic                  item_vld_i,
  output logic                       pop_o,
  input  wire logic [31:0]           angle_step_i,
  input  wire logic signed [31:0]    angle_base_i,
  input  wire logic signed [15:0]    x_shift_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [sptc_pkg::BeamW-1:0] out_beam_o,
  output logic signed [sptc_pkg::OutW-1:0] out_x_o,
  output logic signed [sptc_pkg::OutW-1:0] out_y_o
);

  localparam int unsigned N  = sptc_pkg::CordicIters;
  localparam int unsigned VW = sptc_pkg::VecW;
  localparam int unsigned AG = sptc_pkg::AngW;
  localparam int unsigned BW = sptc_pkg::BeamW;
  localparam logic signed [31:0] Quarter = 32'sd1073741824;

  logic                  en;
  logic                  va_q;
  logic [BW-1:0]         beam_a_q;
  logic [31:0]           ang_a_q;
  logic [39:0]           big_a_q;
  logic [42:0]           ang_prod;

  logic                  vld_q  [N+1];
  logic [BW-1:0]         beam_q [N+1];
  logic signed [VW-1:0]  x_q    [N+1];
  logic signed [VW-1:0]  y_q    [N+1];
  logic signed [AG-1:0]  a_q    [N+1];

  logic signed [31:0]    ang_b;
  logic signed [VW-1:0]  big_b;
  logic signed [VW-1:0]  x0, y0;
  logic signed [AG-1:0]  a0;

  logic signed [VW-1:0]  xr, yr;
  logic signed [28:0]    xs, ys;

  // Advance the whole pipe together; bubbles ride along.
  assign en    = !out_valid_o || out_ready_i;
  assign pop_o = en && item_vld_i;
  assign ang_prod = 43'(item_i.beam) * 43'(angle_step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= item_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      beam_a_q <= item_i.beam;
      ang_a_q  <= ang_prod[31:0];
      big_a_q  <= 40'(item_i.range) * 40'(sptc_pkg::GainQ16);
    end
  end

  // Quadrant fold into the CORDIC's convergence range.
  assign ang_b = $signed(ang_a_q + angle_base_i);
  assign big_b = $signed(VW'(big_a_q));
  always_comb begin
    if (ang_b > Quarter) begin
      x0 = '0;
      y0 = big_b;
      a0 = AG'(ang_b) - AG'(Quarter);
    end else if (ang_b < -Quarter) begin
      x0 = '0;
      y0 = -big_b;
      a0 = AG'(ang_b) + AG'(Quarter);
    end else begin
      x0 = big_b;
      y0 = '0;
      a0 = AG'(ang_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      beam_q[0] <= beam_a_q;
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      a_q[0]    <= a0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [VW-1:0] dx, dy;
    logic signed [AG-1:0] at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed(AG'(sptc_pkg::AtanTab[i]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        beam_q[i+1] <= beam_q[i];
        if (!a_q[i][AG-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          a_q[i+1] <= a_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          a_q[i+1] <= a_q[i] + at;
        end
      end
    end
  end

  // Round to millimetres, add mounting offset, saturate.
  assign xr = (x_q[N] + VW'(32768)) >>> 16;
  assign yr = (y_q[N] + VW'(32768)) >>> 16;
  assign xs = 29'(xr) + 29'(x_shift_i);
  assign ys = 29'(yr);

  function automatic logic signed [sptc_pkg::OutW-1:0] sat(input logic signed [28:0] v);
    logic signed [28:0] hi, lo;
    hi = 29'sd65535;
    lo = -29'sd65536;
    if (v > hi) begin
      sat = 17'sd65535;
    end else if (v < lo) begin
      sat = -17'sd65536;
    end else begin
      sat = v[sptc_pkg::OutW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_beam_o <= beam_q[N];
      out_x_o    <= sat(xs);
      out_y_o    <= sat(ys);
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_x_o) && $stable(out_y_o)))
    else $error("result changed while stalled");
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> item_vld_i) else $error("pop without item");
  a_stage_a_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && item_vld_i) |=> va_q) else $error("popped item lost");
`endif

endmodule
`default_nettype wire
